[rtl/mslr_pkg.sv]
`timescale 1ns / 1ps

package mslr_pkg;

  // sizing
  localparam int NUM_STACKS     = 8;
  localparam int STACK_DEPTH    = 16;
  localparam int MAX_ELEM_BYTES = 8;

  // fixed field widths
  localparam int REQ_W    = 3;
  localparam int HANDLE_W = 4;
  localparam int DATA_W   = 64;
  localparam int SIZE_W   = 4;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 5;

  // derived widths
  localparam int SLOT_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE,
    REQ_PUSH,
    REQ_POP,
    REQ_COUNT,
    REQ_DESTROY,
    REQ_DESTROY_ALL
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_UNKNOWN,
    ST_EMPTY,
    ST_FULL,
    ST_NOFREE
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [HANDLE_W-1:0] stack_handle;
    logic [DATA_W-1:0]   data_in;
    logic [SIZE_W-1:0]   elem_bytes;
  } req_t;

  // keeps the low size bytes of a word
  function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] size);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      m[b*8 +: 8] = (b < int'(size)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

[rtl/mslr_if.sv]
`timescale 1ns / 1ps

interface mslr_req_if;
  import mslr_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [HANDLE_W-1:0] stack_handle;
  logic [DATA_W-1:0]   data_in;
  logic [SIZE_W-1:0]   elem_bytes;

  modport source (output valid, req_type, stack_handle, data_in, elem_bytes, input ready);
  modport sink   (input valid, req_type, stack_handle, data_in, elem_bytes, output ready);
endinterface

interface mslr_rsp_if;
  import mslr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   data_out;
  logic [CNT_W-1:0]    elem_count;
  logic [HANDLE_W-1:0] handle_out;

  modport source (output valid, status, data_out, elem_count, handle_out, input ready);
  modport sink   (input valid, status, data_out, elem_count, handle_out, output ready);
endinterface

[rtl/mslr_ram.sv]
`timescale 1ns / 1ps

module mslr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/multi_stack_lifo_engine.sv]
`timescale 1ns / 1ps

// multiple lifo stacks behind handles 1..NUM_STACKS. while the receiver takes
// results, one request per cycle is taken; its result is offered after the
// input register, then the result register; back-to-back requests run at one
// per cycle with no bubbles. handles, element sizes and fill counts live in
// flip-flops and are updated in the cycle a request leaves the input register,
// so the next request already sees them. elements live in one memory of
// NUM_STACKS*STACK_DEPTH words with one write and one registered read port; a
// pop reads it in the same cycle it updates the fill, the word lands next to
// the result register. no clearing pass is needed after reset: only entries
// below a stack's fill are ever read. elements are masked to the stack's byte
// size on push.
module multi_stack_lifo_engine
  import mslr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  mslr_req_if.sink  req_i,
  mslr_rsp_if.source rsp_o
);

  // input register stage
  logic s1_valid_q;
  req_t s1_req_q;

  // result register stage
  logic                s2_valid_q;
  logic [STATUS_W-1:0] s2_status_q;
  logic [CNT_W-1:0]    s2_count_q;
  logic [HANDLE_W-1:0] s2_handle_q;
  logic                s2_pop_q;

  // per-stack state
  logic              in_use_q [NUM_STACKS];
  logic [SIZE_W-1:0] size_q   [NUM_STACKS];
  logic [FILL_W-1:0] fill_q   [NUM_STACKS];
  logic              in_use_d [NUM_STACKS];
  logic [SIZE_W-1:0] size_d   [NUM_STACKS];
  logic [FILL_W-1:0] fill_d   [NUM_STACKS];

  logic s2_adv;
  logic s1_fire;
  logic in_xfer;

  // handshake: stage 2 drains on ready, stage 1 moves whenever stage 2 moves
  assign s2_adv  = !s2_valid_q || rsp_o.ready;
  assign s1_fire = s1_valid_q && s2_adv;
  assign req_i.ready = !s1_valid_q || s2_adv;
  assign in_xfer = req_i.valid && req_i.ready;

  // handle decode
  logic [HANDLE_W:0]   handle_m1;
  logic [SLOT_W-1:0]   slot;
  logic                handle_ok;
  logic [FILL_W-1:0]   fill_cur;
  logic [SIZE_W-1:0]   size_cur;

  assign handle_m1 = {1'b0, s1_req_q.stack_handle} - (HANDLE_W+1)'(1);
  assign slot      = SLOT_W'(handle_m1);

  always_comb begin
    handle_ok = 1'b0;
    fill_cur  = '0;
    size_cur  = '0;
    if (s1_req_q.stack_handle != '0 && int'(s1_req_q.stack_handle) <= NUM_STACKS) begin
      handle_ok = in_use_q[slot];
      fill_cur  = fill_q[slot];
      size_cur  = size_q[slot];
    end
  end

  // lowest free stack for create
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NUM_STACKS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  // create size, clamped to 1..MAX_ELEM_BYTES
  logic [SIZE_W-1:0] new_size;

  always_comb begin
    if (s1_req_q.elem_bytes == '0) begin
      new_size = SIZE_W'(1);
    end else if (int'(s1_req_q.elem_bytes) > MAX_ELEM_BYTES) begin
      new_size = SIZE_W'(MAX_ELEM_BYTES);
    end else begin
      new_size = s1_req_q.elem_bytes;
    end
  end

  // request execution
  logic [STATUS_W-1:0] res_status;
  logic [CNT_W-1:0]    res_count;
  logic [HANDLE_W-1:0] res_handle;
  logic                res_pop;
  logic                mem_we;
  logic                mem_re;
  logic [FILL_W-1:0]   mem_ptr;
  logic [ADDR_W-1:0]   mem_addr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [DATA_W-1:0]   mem_rdata;

  always_comb begin
    for (int i = 0; i < NUM_STACKS; i++) begin
      in_use_d[i] = in_use_q[i];
      size_d[i]   = size_q[i];
      fill_d[i]   = fill_q[i];
    end
    res_status = ST_OK;
    res_count  = '0;
    res_handle = '0;
    res_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_ptr    = fill_cur;

    unique case (req_type_e'(s1_req_q.req_type))
      REQ_CREATE: begin
        if (!free_found) begin
          res_status = ST_NOFREE;
        end else begin
          in_use_d[free_slot] = 1'b1;
          size_d[free_slot]   = new_size;
          fill_d[free_slot]   = '0;
          res_handle          = HANDLE_W'(int'(free_slot) + 1);
        end
      end
      REQ_PUSH: begin
        if (!handle_ok) begin
          res_status = ST_UNKNOWN;
        end else if (fill_cur == FILL_W'(STACK_DEPTH)) begin
          res_status = ST_FULL;
          res_count  = CNT_W'(fill_cur);
        end else begin
          mem_we       = 1'b1;
          fill_d[slot] = fill_cur + FILL_W'(1);
          res_count    = CNT_W'(fill_cur + FILL_W'(1));
        end
      end
      REQ_POP: begin
        if (!handle_ok) begin
          res_status = ST_UNKNOWN;
        end else if (fill_cur == '0) begin
          res_status = ST_EMPTY;
        end else begin
          mem_re       = 1'b1;
          res_pop      = 1'b1;
          mem_ptr      = fill_cur - FILL_W'(1);
          fill_d[slot] = fill_cur - FILL_W'(1);
          res_count    = CNT_W'(fill_cur - FILL_W'(1));
        end
      end
      REQ_COUNT: begin
        if (!handle_ok) begin
          res_status = ST_UNKNOWN;
        end else begin
          res_count = CNT_W'(fill_cur);
        end
      end
      REQ_DESTROY: begin
        if (!handle_ok) begin
          res_status = ST_UNKNOWN;
        end else begin
          in_use_d[slot] = 1'b0;
          size_d[slot]   = '0;
          fill_d[slot]   = '0;
        end
      end
      REQ_DESTROY_ALL: begin
        for (int i = 0; i < NUM_STACKS; i++) begin
          in_use_d[i] = 1'b0;
          size_d[i]   = '0;
          fill_d[i]   = '0;
        end
      end
      default: begin
        // undefined request codes leave everything alone
      end
    endcase
  end

  assign mem_addr  = ADDR_W'(int'(slot) * STACK_DEPTH + int'(mem_ptr));
  assign mem_wdata = s1_req_q.data_in & byte_mask(size_cur);

  mslr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s1_fire && mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (s1_fire && mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  // stack state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        in_use_q[i] <= 1'b0;
        size_q[i]   <= '0;
        fill_q[i]   <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        in_use_q[i] <= in_use_d[i];
        size_q[i]   <= size_d[i];
        fill_q[i]   <= fill_d[i];
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= in_xfer;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q.req_type     <= req_i.req_type;
      s1_req_q.stack_handle <= req_i.stack_handle;
      s1_req_q.data_in      <= req_i.data_in;
      s1_req_q.elem_bytes   <= req_i.elem_bytes;
    end
    if (s1_fire) begin
      s2_status_q <= res_status;
      s2_count_q  <= res_count;
      s2_handle_q <= res_handle;
      s2_pop_q    <= res_pop;
    end
  end

  assign rsp_o.valid      = s2_valid_q;
  assign rsp_o.status     = s2_status_q;
  assign rsp_o.elem_count = s2_count_q;
  assign rsp_o.handle_out = s2_handle_q;
  // read word is held by the memory until the next pop leaves stage 1
  assign rsp_o.data_out   = s2_pop_q ? mem_rdata : '0;

endmodule

[rtl/mslr_checker.sv]
`timescale 1ns / 1ps

module mslr_checker
  import mslr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [DATA_W-1:0]   data_out_i,
  input logic [CNT_W-1:0]    elem_count_i,
  input logic [HANDLE_W-1:0] handle_out_i
);

  // a waiting result stays until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped before transfer");

  // a fresh result follows a request transfer through the input and result registers
  a_rsp_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_valid_i && req_ready_i, 2))
    else $error("result without a matching request");

  // a handle is handed out only by a clean create
  a_create_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && handle_out_i != '0 |->
      status_i == ST_OK && data_out_i == '0 && elem_count_i == '0)
    else $error("handle with other fields set");

  // empty pop gives nothing back
  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_EMPTY |->
      data_out_i == '0 && elem_count_i == '0 && handle_out_i == '0)
    else $error("empty status with payload");

endmodule

bind multi_stack_lifo_engine mslr_checker u_mslr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .data_out_i   (rsp_o.data_out),
  .elem_count_i (rsp_o.elem_count),
  .handle_out_i (rsp_o.handle_out)
);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mslr_pkg::*;

  // receiver behavior between phases
  localparam int RCV_ALWAYS   = 0;
  localparam int RCV_LIGHT    = 1;
  localparam int RCV_PERIODIC = 2;
  localparam int RCV_HEAVY    = 3;

  // request codes the package leaves unnamed
  localparam logic [REQ_W-1:0] REQ_UNDEF_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNDEF_7 = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic [CNT_W-1:0]    elem_count;
    logic [HANDLE_W-1:0] handle_out;
  } stack_reply_t;

  // mirrors the stack state and queues the reply each accepted request earns
  class lifo_scoreboard;
    bit                  in_use    [NUM_STACKS];
    logic [SIZE_W-1:0]   elem_size [NUM_STACKS];
    int unsigned         fill      [NUM_STACKS];
    logic [DATA_W-1:0]   store     [STORE_DEPTH];
    stack_reply_t        expected_replies [$];
    int unsigned         mismatches;

    function new();
      mismatches = 0;
      free_all();
    endfunction

    function void free_all();
      for (int i = 0; i < NUM_STACKS; i++) begin
        in_use[i]    = 1'b0;
        elem_size[i] = '0;
        fill[i]      = 0;
      end
    endfunction

    static function logic [DATA_W-1:0] low_bytes(int unsigned nbytes);
      if (nbytes >= 8) return '1;
      return (64'd1 << (8 * nbytes)) - 64'd1;
    endfunction

    // -1 when the handle names no live stack
    function int slot_of(logic [HANDLE_W-1:0] h);
      if (h < 1 || h > NUM_STACKS) return -1;
      if (!in_use[h - 1]) return -1;
      return int'(h) - 1;
    endfunction

    function logic [HANDLE_W-1:0] pick_live();
      int live [$];
      for (int i = 0; i < NUM_STACKS; i++) begin
        if (in_use[i]) live.push_back(i + 1);
      end
      if (live.size() == 0) return '0;
      return HANDLE_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    function stack_reply_t predict_reply(req_t r);
      stack_reply_t rep;
      int           slot;
      int unsigned  sz;
      rep.status     = ST_OK;
      rep.data_out   = '0;
      rep.elem_count = '0;
      rep.handle_out = '0;
      slot = slot_of(r.stack_handle);
      case (r.req_type)
        REQ_CREATE: begin
          slot = -1;
          for (int i = 0; i < NUM_STACKS; i++) begin
            if (!in_use[i] && slot < 0) slot = i;
          end
          if (slot < 0) begin
            rep.status = ST_NOFREE;
          end else begin
            // out-of-range sizes clamp to 1..MAX_ELEM_BYTES
            sz = r.elem_bytes;
            if (sz < 1) sz = 1;
            if (sz > MAX_ELEM_BYTES) sz = MAX_ELEM_BYTES;
            in_use[slot]    = 1'b1;
            elem_size[slot] = SIZE_W'(sz);
            fill[slot]      = 0;
            rep.handle_out  = HANDLE_W'(slot + 1);
          end
        end
        REQ_PUSH: begin
          if (slot < 0) begin
            rep.status = ST_UNKNOWN;
          end else if (fill[slot] >= STACK_DEPTH) begin
            rep.status     = ST_FULL;
            rep.elem_count = CNT_W'(fill[slot]);
          end else begin
            store[slot * STACK_DEPTH + fill[slot]] =
              r.data_in & low_bytes(elem_size[slot]);
            fill[slot]++;
            rep.elem_count = CNT_W'(fill[slot]);
          end
        end
        REQ_POP: begin
          if (slot < 0) begin
            rep.status = ST_UNKNOWN;
          end else if (fill[slot] == 0) begin
            rep.status = ST_EMPTY;
          end else begin
            fill[slot]--;
            rep.data_out   = store[slot * STACK_DEPTH + fill[slot]] &
                             low_bytes(elem_size[slot]);
            rep.elem_count = CNT_W'(fill[slot]);
          end
        end
        REQ_COUNT: begin
          if (slot < 0) rep.status = ST_UNKNOWN;
          else rep.elem_count = CNT_W'(fill[slot]);
        end
        REQ_DESTROY: begin
          if (slot < 0) begin
            rep.status = ST_UNKNOWN;
          end else begin
            in_use[slot]    = 1'b0;
            elem_size[slot] = '0;
            fill[slot]      = 0;
          end
        end
        REQ_DESTROY_ALL: free_all();
        default: ;
      endcase
      return rep;
    endfunction

    function void note_request(req_t r);
      expected_replies.push_back(predict_reply(r));
    endfunction

    function void check_reply(stack_reply_t got);
      stack_reply_t want;
      if (expected_replies.size() == 0) begin
        $error("reply with no request pending: status %0d", got.status);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.data_out !== want.data_out) begin
        $error("data_out: expected %h, actual %h", want.data_out, got.data_out);
        mismatches++;
      end
      if (got.elem_count !== want.elem_count) begin
        $error("elem_count: expected %0d, actual %0d", want.elem_count, got.elem_count);
        mismatches++;
      end
      if (got.handle_out !== want.handle_out) begin
        $error("handle_out: expected %0d, actual %0d", want.handle_out, got.handle_out);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mslr_req_if req_if ();
  mslr_rsp_if rsp_if ();

  multi_stack_lifo_engine u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  lifo_scoreboard sb;
  int unsigned    sent;
  int unsigned    burst_left;
  bit             gaps_on;
  int             rcv_mode;
  bit             long_hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous cap, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("multi_stack_lifo_engine regression: fail");
    $finish;
  end

  // receiver ready pattern, driven on the falling edge
  initial begin
    int unsigned hold_left;
    int unsigned cyc;
    rsp_if.ready = 1'b0;
    hold_left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // long back-pressure so the block fills and stalls its input
        hold_left--;
        rsp_if.ready = 1'b0;
      end else begin
        case (rcv_mode)
          RCV_ALWAYS:   rsp_if.ready = 1'b1;
          RCV_LIGHT:    rsp_if.ready = ($urandom_range(0, 3) != 0);
          RCV_PERIODIC: rsp_if.ready = ((cyc % 7) < 4);
          default:      rsp_if.ready = ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // reply monitor, sampled on the rising edge
  initial begin
    stack_reply_t got;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got.status     = rsp_if.status;
        got.data_out   = rsp_if.data_out;
        got.elem_count = rsp_if.elem_count;
        got.handle_out = rsp_if.handle_out;
        sb.check_reply(got);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one request: offered on the falling edge, held until the transfer
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [HANDLE_W-1:0] h,
                          input logic [DATA_W-1:0] d, input logic [SIZE_W-1:0] eb);
    req_t r;
    r.req_type     = kind;
    r.stack_handle = h;
    r.data_in      = d;
    r.elem_bytes   = eb;
    @(negedge clk);
    req_if.valid        = 1'b1;
    req_if.req_type     = r.req_type;
    req_if.stack_handle = r.stack_handle;
    req_if.data_in      = r.data_in;
    req_if.elem_bytes   = r.elem_bytes;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(r);
    sent++;
    // bursts of random length separated by random gaps
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          req_if.valid = 1'b0;
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic rand_any();
    send_req(REQ_W'($urandom_range(0, 7)), HANDLE_W'($urandom_range(0, 15)), rand_word(),
             SIZE_W'($urandom_range(0, 15)));
  endtask

  // well-formed runs on live stacks with random content, plus some noise
  task automatic run_sequence();
    logic [HANDLE_W-1:0] h;
    int unsigned         n;
    int unsigned         op;
    h = sb.pick_live();
    n = $urandom_range(1, 20);
    if (h == 0 && $urandom_range(0, 3) != 0) begin
      send_req(REQ_CREATE, HANDLE_W'($urandom_range(0, 15)), rand_word(),
               SIZE_W'($urandom_range(0, 15)));
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // long push runs reach the full case
        repeat (n) send_req(REQ_PUSH, h, rand_word(), SIZE_W'($urandom_range(0, 15)));
      end
      3, 4: begin
        repeat (n) send_req(REQ_POP, h, rand_word(), SIZE_W'($urandom_range(0, 15)));
      end
      5: begin
        // enough creates in a row to run out of free stacks now and then
        repeat ($urandom_range(1, 9)) begin
          send_req(REQ_CREATE, HANDLE_W'($urandom_range(0, 15)), rand_word(),
                   SIZE_W'($urandom_range(0, 15)));
        end
      end
      6: begin
        send_req(REQ_DESTROY, h, rand_word(), SIZE_W'($urandom_range(0, 15)));
        send_req(REQ_COUNT, h, rand_word(), SIZE_W'($urandom_range(0, 15)));
      end
      7: begin
        repeat (10) begin
          h = sb.pick_live();
          if ($urandom_range(0, 7) == 0) h = HANDLE_W'($urandom_range(0, 15));
          op = $urandom_range(0, 5);
          send_req((op < 2) ? REQ_PUSH : (op < 5) ? REQ_POP : REQ_COUNT, h, rand_word(),
                   SIZE_W'($urandom_range(0, 15)));
        end
      end
      8: repeat (4) rand_any();
      default: begin
        if ($urandom_range(0, 3) == 0)
          send_req(REQ_DESTROY_ALL, HANDLE_W'($urandom_range(0, 15)), rand_word(),
                   SIZE_W'($urandom_range(0, 15)));
        else
          send_req(REQ_COUNT, HANDLE_W'($urandom_range(0, 15)), rand_word(),
                   SIZE_W'($urandom_range(0, 15)));
      end
    endcase
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    sb = new();
    sent          = 0;
    burst_left    = 0;
    gaps_on       = 1'b0;
    rcv_mode      = RCV_LIGHT;
    long_hold_req = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = '0;
    req_if.stack_handle = '0;
    req_if.data_in      = '0;
    req_if.elem_bytes   = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: size clamping, masking, empty, unknown handles, reuse, undefined codes
    send_req(REQ_CREATE, 4'd0, '0, 4'd0);
    send_req(REQ_CREATE, 4'd0, '0, 4'd8);
    send_req(REQ_CREATE, 4'd15, '0, 4'd15);
    send_req(REQ_CREATE, 4'd0, '0, 4'd3);
    send_req(REQ_PUSH, 4'd1, '1, 4'd0);
    send_req(REQ_PUSH, 4'd2, '1, 4'd0);
    send_req(REQ_PUSH, 4'd4, 64'h0123_4567_89ab_cdef, 4'd15);
    send_req(REQ_POP, 4'd4, '0, 4'd0);
    send_req(REQ_POP, 4'd1, '0, 4'd0);
    send_req(REQ_POP, 4'd1, '1, 4'd0);
    send_req(REQ_COUNT, 4'd2, '0, 4'd0);
    send_req(REQ_PUSH, 4'd0, '1, 4'd0);
    send_req(REQ_POP, 4'd15, '0, 4'd0);
    send_req(REQ_COUNT, 4'd9, '0, 4'd0);
    send_req(REQ_DESTROY, 4'd8, '0, 4'd0);
    send_req(REQ_DESTROY, 4'd3, '0, 4'd0);
    send_req(REQ_COUNT, 4'd3, '0, 4'd0);
    send_req(REQ_CREATE, 4'd0, '0, 4'd1);
    send_req(REQ_UNDEF_6, 4'd1, '1, 4'd15);
    send_req(REQ_UNDEF_7, 4'd2, '1, 4'd15);
    send_req(REQ_DESTROY_ALL, 4'd0, '0, 4'd0);
    send_req(REQ_POP, 4'd2, '0, 4'd0);
    send_req(REQ_CREATE, 4'd0, '0, 4'd4);
    wait_drained();

    phase = 0;
    phase_end = sent + PHASE_ITEMS;
    gaps_on = 1'b0;
    rcv_mode = RCV_ALWAYS;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= phase_end) begin
        // pause the sender until every reply is in, then change the idling mix
        wait_drained();
        phase++;
        phase_end = sent + PHASE_ITEMS;
        rcv_mode  = phase % 4;
        gaps_on   = (phase % 3 != 0);
        if (phase == 2 || phase == 5) long_hold_req = 1'b1;
      end
      run_sequence();
    end
    wait_drained();

    if (sb.mismatches == 0) begin
      $display("multi_stack_lifo_engine regression: pass");
    end else begin
      $display("multi_stack_lifo_engine regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mslr_pkg.sv
rtl/mslr_if.sv
rtl/mslr_ram.sv
rtl/multi_stack_lifo_engine.sv
rtl/mslr_checker.sv
verif/testbench.sv
